/* sv/keyframe_path_interpolator_defines.svh */
// ----------------------------------------------------------------------------
// Keyframe path interpolator - assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_PATH_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_PATH_INTERPOLATOR_DEFINES_SVH

// Checked only out of reset.
`define KPI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define KPI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/kpi_pkg.sv */
// ----------------------------------------------------------------------------
// Keyframe path interpolator - package
// Codes, controller/datapath command and status types, ease table builder.
// ----------------------------------------------------------------------------
package kpi_pkg;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_START  = 2'd1,
    REQ_TICK   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    MODE_LINEAR = 2'd0,
    MODE_COSINE = 2'd1,
    MODE_CUBIC  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    OUT_ZERO,
    OUT_POS,
    OUT_DONE,
    OUT_REJECT
  } out_kind_e;

  typedef enum logic [2:0] {
    BL_LIN_FIRST,
    BL_CUB_FIRST,
    BL_Q,
    BL_R,
    BL_FINISH
  } blend_op_e;

  localparam int DivSteps = 16;
  localparam int FetchLast = 4;

  typedef struct packed {
    logic       append;
    logic       start;
    logic       tick;
    logic       finish;
    logic       scan_start;
    logic       scan_step;
    logic       fact_load;
    logic       div_step;
    logic       ease;
    logic       fetch_step;
    logic [2:0] fetch_sel;
    logic       blend_en;
    blend_op_e  blend_op;
    logic [1:0] blend_axis;
    logic       out_load;
    out_kind_e  out_kind;
  } kpi_cmd_t;

  typedef struct packed {
    logic       in_motion;
    logic       cnt_full;
    logic       end_hit;
    logic       scan_last;
    logic       need_div;
    logic [1:0] mode;
  } kpi_sts_t;

  // (1 - cos(pi*i/N)) / 2 in Q1.16, cosine from a 7-term series in Q30,
  // upper half mirrored from the lower half.
  function automatic logic [16:0] kpi_ease_entry(input int idx, input int bits);
    longint one_q30;
    longint pi_q30;
    longint x;
    longint x2;
    longint t;
    longint num;
    longint e;
    int     half;
    int     n;
    int     j;
    int     k;
    logic   mirror;
    one_q30 = longint'(1) << 30;
    pi_q30  = 64'sd3373259426;
    n       = 1 << bits;
    half    = n >> 1;
    mirror  = (idx > half);
    j       = mirror ? (n - idx) : idx;
    x       = (pi_q30 * longint'(j)) >> bits;
    x2      = (x * x) >> 30;
    t       = one_q30;
    for (k = 7; k >= 1; k--) begin
      num = (x2 * t) >> 30;
      unique case (k)
        1:       num = num / 2;
        2:       num = num / 12;
        3:       num = num / 30;
        4:       num = num / 56;
        5:       num = num / 90;
        6:       num = num / 132;
        default: num = num / 182;
      endcase
      t = one_q30 - num;
      if (t < 0) t = 0;
      if (t > one_q30) t = one_q30;
    end
    e = ((one_q30 - t) + (longint'(1) << 14)) >> 15;
    if (mirror) e = 65536 - e;
    return 17'(e);
  endfunction

endpackage

/* sv/keyframe_path_interpolator.sv */
// ----------------------------------------------------------------------------
// Keyframe path interpolator - top level
// Timed 3-D keyframe table with linear, cosine-eased or cubic blending.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+--------------------------------------
//  s_axis   | in  | tvalid / tready   | tuser req_type, tdata time,x,y,z
//  m_axis   | out | tvalid / tready   | tdata pos x,y,z, tuser flags
//  apb      | in  | psel/penable/pwrite| reg 0 interp_mode at byte 0
//
// A tick in motion scans the keys, loads the factor, divides (only between
// keys), eases (cosine only), reads the table and blends each axis in turn;
// the single table read port and the shared blend multiplier serialise
// this work. Other items, and ticks that are idle or end the motion, skip it.
// Reset is asynchronous and immediate; no clearing pass is needed.
// A result waiting on m_axis does not stop the next item being taken; it
// only holds back that item's own result.
// ----------------------------------------------------------------------------
module keyframe_path_interpolator #(
  parameter int MAX_KEYS      = 16,
  parameter int EASE_ROM_BITS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // item in
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,  // key_time[31:0], key_x, key_y, key_z
  input  logic [1:0]   s_axis_tuser_i,  // req_type[1:0]
  // item out
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [95:0]  m_axis_tdata_o,  // pos_x[31:0], pos_y, pos_z
  output logic [2:0]   m_axis_tuser_o,  // pos_valid, motion_done, key_rejected
  // config
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [1:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  output logic [31:0]  prdata_o,
  output logic         pready_o
);
  import kpi_pkg::*;

  kpi_cmd_t   cmd;
  kpi_sts_t   sts;
  logic [1:0] mode;
  logic       cfg_we;
  logic       pos_valid, motion_done, key_rejected;

  // single register, so every word address lands on interp_mode
  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i && (paddr_i[1:0] == 2'b00 || 1'b1);
  assign prdata_o = {30'd0, mode};

  kpi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid_i),
    .req_type_i (s_axis_tuser_i),
    .s_ready_o  (s_axis_tready_o),
    .m_ready_i  (m_axis_tready_i),
    .m_valid_o  (m_axis_tvalid_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kpi_dp #(
    .MAX_KEYS      (MAX_KEYS),
    .EASE_ROM_BITS (EASE_ROM_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .key_time_i     (s_axis_tdata_i[31:0]),
    .key_x_i        (s_axis_tdata_i[63:32]),
    .key_y_i        (s_axis_tdata_i[95:64]),
    .key_z_i        (s_axis_tdata_i[127:96]),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata_i[1:0]),
    .mode_o         (mode),
    .pos_x_o        (m_axis_tdata_o[31:0]),
    .pos_y_o        (m_axis_tdata_o[63:32]),
    .pos_z_o        (m_axis_tdata_o[95:64]),
    .pos_valid_o    (pos_valid),
    .motion_done_o  (motion_done),
    .key_rejected_o (key_rejected)
  );

  assign m_axis_tuser_o = {key_rejected, motion_done, pos_valid};

endmodule

/* sv/kpi_ram.sv */
// ----------------------------------------------------------------------------
// Keyframe path interpolator - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/kpi_ctrl.sv */
// ----------------------------------------------------------------------------
// Keyframe path interpolator - controller
// Sequences append/start/tick items through scan, divide, ease, fetch, blend.
// ----------------------------------------------------------------------------
module kpi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic [1:0]        req_type_i,
  output logic              s_ready_o,
  input  logic              m_ready_i,
  output logic              m_valid_o,
  input  kpi_pkg::kpi_sts_t sts_i,
  output kpi_pkg::kpi_cmd_t cmd_o
);
  import kpi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FACTOR,
    S_DIVIDE,
    S_EASE,
    S_FETCH,
    S_BLEND,
    S_EMIT
  } state_e;

  state_e    state_q;
  logic [3:0] cnt_q;
  logic [1:0] axis_q;
  out_kind_e  kind_q;
  logic       out_valid_q;

  logic       fire;
  logic       slot_free;
  logic       cubic;
  logic       cosine;
  blend_op_e  op;

  always_comb begin
    fire      = s_valid_i && (state_q == S_IDLE);
    slot_free = !out_valid_q || m_ready_i;
    cubic     = (sts_i.mode == MODE_CUBIC);
    cosine    = (sts_i.mode == MODE_COSINE);
    if (cubic) begin
      unique case (cnt_q)
        4'd0:    op = BL_CUB_FIRST;
        4'd1:    op = BL_Q;
        4'd2:    op = BL_R;
        default: op = BL_FINISH;
      endcase
    end else begin
      op = (cnt_q == 4'd0) ? BL_LIN_FIRST : BL_FINISH;
    end
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (fire) begin
          case (req_type_i)
            REQ_APPEND: cmd_o.append = !sts_i.cnt_full;
            REQ_START:  cmd_o.start  = 1'b1;
            REQ_TICK:   cmd_o.tick   = 1'b1;
            default:    ;
          endcase
        end
      end
      S_CHECK: begin
        cmd_o.scan_start = sts_i.in_motion && !sts_i.end_hit;
        cmd_o.finish     = sts_i.in_motion && sts_i.end_hit;
      end
      S_SCAN:   cmd_o.scan_step = 1'b1;
      S_FACTOR: cmd_o.fact_load = 1'b1;
      S_DIVIDE: cmd_o.div_step  = 1'b1;
      S_EASE:   cmd_o.ease      = 1'b1;
      S_FETCH: begin
        cmd_o.fetch_step = 1'b1;
        cmd_o.fetch_sel  = cnt_q[2:0];
      end
      S_BLEND: begin
        cmd_o.blend_en   = 1'b1;
        cmd_o.blend_op   = op;
        cmd_o.blend_axis = axis_q;
      end
      S_EMIT: begin
        cmd_o.out_load = slot_free;
        cmd_o.out_kind = kind_q;
      end
      default: ;
    endcase
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      axis_q      <= '0;
      kind_q      <= OUT_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_EMIT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (fire) begin
            kind_q  <= (req_type_i == REQ_APPEND && sts_i.cnt_full) ? OUT_REJECT : OUT_ZERO;
            state_q <= (req_type_i == REQ_TICK) ? S_CHECK : S_EMIT;
          end
        end
        S_CHECK: begin
          if (!sts_i.in_motion) begin
            kind_q  <= OUT_ZERO;
            state_q <= S_EMIT;
          end else if (sts_i.end_hit) begin
            kind_q  <= OUT_DONE;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts_i.scan_last) state_q <= S_FACTOR;
        end
        S_FACTOR: begin
          cnt_q <= '0;
          priority if (sts_i.need_div) state_q <= S_DIVIDE;
          else if (cosine)             state_q <= S_EASE;
          else                         state_q <= S_FETCH;
        end
        S_DIVIDE: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'(DivSteps - 1)) begin
            cnt_q   <= '0;
            state_q <= cosine ? S_EASE : S_FETCH;
          end
        end
        S_EASE: begin
          cnt_q   <= '0;
          state_q <= S_FETCH;
        end
        S_FETCH: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'(FetchLast)) begin
            cnt_q   <= '0;
            axis_q  <= '0;
            state_q <= S_BLEND;
          end
        end
        S_BLEND: begin
          if (op == BL_FINISH) begin
            cnt_q <= '0;
            if (axis_q == 2'd2) begin
              kind_q  <= OUT_POS;
              state_q <= S_EMIT;
            end else begin
              axis_q <= axis_q + 2'd1;
            end
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        S_EMIT: begin
          if (slot_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/kpi_dp.sv */
// ----------------------------------------------------------------------------
// Keyframe path interpolator - datapath
// Key table, counters, scan, serial divider, ease table, blend multiplier.
// ----------------------------------------------------------------------------
module kpi_dp #(
  parameter int MAX_KEYS      = 16,
  parameter int EASE_ROM_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kpi_pkg::kpi_cmd_t cmd_i,
  output kpi_pkg::kpi_sts_t sts_o,
  input  logic [31:0]       key_time_i,
  input  logic [31:0]       key_x_i,
  input  logic [31:0]       key_y_i,
  input  logic [31:0]       key_z_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  output logic [1:0]        mode_o,
  output logic [31:0]       pos_x_o,
  output logic [31:0]       pos_y_o,
  output logic [31:0]       pos_z_o,
  output logic              pos_valid_o,
  output logic              motion_done_o,
  output logic              key_rejected_o
);
  import kpi_pkg::*;

  localparam int IW   = $clog2(MAX_KEYS);
  localparam int CW   = $clog2(MAX_KEYS + 1);
  localparam int SH   = 16 - EASE_ROM_BITS;
  localparam int RomN = 1 << EASE_ROM_BITS;
  localparam int AW   = 40;
  localparam int PW   = AW + 18;
  localparam logic signed [PW-1:0] RoundHalf = PW'(32768);

  // control state
  logic [CW-1:0] cnt_q;
  logic [31:0]   tick_q;
  logic          motion_q;
  logic [1:0]    mode_q;

  // payload
  logic [31:0]   last_time_q;
  logic [IW-1:0] chk_q, ia_q, ib_q, iba_q, iab_q;
  logic [31:0]   ta_q, tb_q;
  logic          fzero_q;
  logic [16:0]   f_q;
  logic [31:0]   rem_q, d_q;
  logic [15:0]   quo_q;
  logic signed [31:0] pt_q [4][3];
  logic signed [PW-1:0] prod_q;
  logic [31:0]   res_q [3];

  // table
  logic          ram_we;
  logic [IW-1:0] ram_raddr;
  logic [127:0]  ram_rdata;
  logic [31:0]   rd_time;

  kpi_ram #(.WIDTH(128), .DEPTH(MAX_KEYS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i ({key_z_i, key_y_i, key_x_i, key_time_i}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_we  = cmd_i.append;
  assign rd_time = ram_rdata[31:0];

  // scan
  logic [CW-1:0] chk_p1;
  logic          hit;
  logic          scan_last;
  assign chk_p1    = CW'(chk_q) + CW'(1);
  assign hit       = (rd_time >= tick_q);
  assign scan_last = hit || (chk_p1 == cnt_q);

  always_comb begin
    priority if (cmd_i.scan_start) ram_raddr = '0;
    else if (cmd_i.scan_step)      ram_raddr = chk_p1[IW-1:0];
    else if (cmd_i.fetch_step) begin
      unique case (cmd_i.fetch_sel)
        3'd0:    ram_raddr = iba_q;
        3'd1:    ram_raddr = ia_q;
        3'd2:    ram_raddr = ib_q;
        3'd3:    ram_raddr = iab_q;
        default: ram_raddr = '0;
      endcase
    end else ram_raddr = '0;
  end

  // factor
  logic        t_eq_a, t_eq_b, need_div;
  logic [16:0] f_init;
  always_comb begin
    t_eq_a   = (tick_q == ta_q);
    t_eq_b   = (tick_q == tb_q);
    need_div = !fzero_q && !t_eq_a && !t_eq_b && (tb_q > ta_q) && (tick_q > ta_q);
    f_init   = (!fzero_q && !t_eq_a && t_eq_b) ? 17'h10000 : 17'h00000;
  end

  // divider, one quotient bit a cycle
  logic [32:0] div_r2;
  logic        div_ge;
  logic [31:0] div_rem;
  logic [15:0] div_quo;
  always_comb begin
    div_r2  = {rem_q, 1'b0};
    div_ge  = (div_r2 >= {1'b0, d_q});
    div_rem = div_ge ? 32'(div_r2 - {1'b0, d_q}) : div_r2[31:0];
    div_quo = {quo_q[14:0], div_ge};
  end

  // ease table, linearly interpolated
  logic [16:0] rom_w [RomN+1];
  for (genvar g = 0; g <= RomN; g++) begin : g_rom
    assign rom_w[g] = kpi_ease_entry(g, EASE_ROM_BITS);
  end

  logic [EASE_ROM_BITS:0] e_idx, e_idx1;
  logic signed [17:0]     e_diff;
  logic signed [SH:0]     e_frac;
  logic signed [18+SH:0]  e_prod, e_shift;
  logic signed [17:0]     e_sum;
  always_comb begin
    e_idx   = f_q[16:SH];
    e_idx1  = (e_idx == (EASE_ROM_BITS+1)'(RomN)) ? e_idx : e_idx + (EASE_ROM_BITS+1)'(1);
    e_diff  = signed'({1'b0, rom_w[e_idx1]}) - signed'({1'b0, rom_w[e_idx]});
    e_frac  = signed'({1'b0, f_q[SH-1:0]});
    e_prod  = e_diff * e_frac;
    e_shift = e_prod >>> SH;
    e_sum   = 18'(e_shift) + signed'({1'b0, rom_w[e_idx]});
  end

  // blend, one multiply a cycle
  logic [1:0]            ax;
  logic signed [AW-1:0]  pb_e, pa_e, pbb_e, pab_e, p_v, q_v, r_v, rnd, m_a, fin;
  logic signed [PW-1:0]  rnd_full;
  logic signed [17:0]    fs;
  logic [31:0]           sat_v;
  always_comb begin
    ax       = cmd_i.blend_axis;
    pb_e     = AW'(pt_q[0][ax]);
    pa_e     = AW'(pt_q[1][ax]);
    pbb_e    = AW'(pt_q[2][ax]);
    pab_e    = AW'(pt_q[3][ax]);
    p_v      = (pab_e - pbb_e) - (pb_e - pa_e);
    q_v      = (pb_e - pa_e) - p_v;
    r_v      = pbb_e - pb_e;
    rnd_full = (prod_q + RoundHalf) >>> 16;
    rnd      = signed'(rnd_full[AW-1:0]);
    fs       = signed'({1'b0, f_q});
    case (cmd_i.blend_op)
      BL_LIN_FIRST: m_a = pbb_e - pa_e;
      BL_CUB_FIRST: m_a = p_v;
      BL_Q:         m_a = rnd + q_v;
      BL_R:         m_a = rnd + r_v;
      default:      m_a = '0;
    endcase
    fin = rnd + pa_e;
    if ((&fin[AW-1:31]) || !(|fin[AW-1:31])) sat_v = fin[31:0];
    else sat_v = fin[AW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  end

  // status
  always_comb begin
    sts_o.in_motion = motion_q;
    sts_o.cnt_full  = (cnt_q == CW'(MAX_KEYS));
    sts_o.end_hit   = (cnt_q == '0) || ((cnt_q > CW'(1)) && (last_time_q <= tick_q));
    sts_o.scan_last = scan_last;
    sts_o.need_div  = need_div;
    sts_o.mode      = mode_q;
  end
  assign mode_o = mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      tick_q   <= '0;
      motion_q <= 1'b0;
      mode_q   <= MODE_LINEAR;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (cmd_i.append) cnt_q <= cnt_q + CW'(1);
      if (cmd_i.start) motion_q <= 1'b1;
      if (cmd_i.tick) tick_q <= tick_q + 32'd1;
      if (cmd_i.finish) begin
        motion_q <= 1'b0;
        cnt_q    <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) last_time_q <= key_time_i;
    if (cmd_i.scan_start) begin
      chk_q   <= '0;
      ia_q    <= '0;
      ib_q    <= '0;
      iba_q   <= '0;
      iab_q   <= '0;
      fzero_q <= 1'b0;
    end
    if (cmd_i.scan_step) begin
      chk_q <= chk_p1[IW-1:0];
      if (hit) begin
        ib_q  <= chk_q;
        iab_q <= (chk_p1 < cnt_q) ? chk_p1[IW-1:0] : chk_q;
        tb_q  <= rd_time;
        if (chk_q == '0) ta_q <= rd_time;
      end else begin
        iba_q <= ia_q;
        ia_q  <= chk_q;
        ta_q  <= rd_time;
        if (scan_last) fzero_q <= 1'b1;
      end
    end
    if (cmd_i.fact_load) begin
      f_q   <= f_init;
      rem_q <= tick_q - ta_q;
      d_q   <= tb_q - ta_q;
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= div_rem;
      quo_q <= div_quo;
      f_q   <= {1'b0, div_quo};
    end
    if (cmd_i.ease) f_q <= e_sum[16:0];
    if (cmd_i.fetch_step && cmd_i.fetch_sel != 3'd0) begin
      pt_q[2'(cmd_i.fetch_sel - 3'd1)][0] <= ram_rdata[63:32];
      pt_q[2'(cmd_i.fetch_sel - 3'd1)][1] <= ram_rdata[95:64];
      pt_q[2'(cmd_i.fetch_sel - 3'd1)][2] <= ram_rdata[127:96];
    end
    if (cmd_i.blend_en) begin
      prod_q <= m_a * fs;
      if (cmd_i.blend_op == BL_FINISH) res_q[ax] <= sat_v;
    end
    if (cmd_i.out_load) begin
      pos_valid_o    <= (cmd_i.out_kind == OUT_POS);
      motion_done_o  <= (cmd_i.out_kind == OUT_DONE);
      key_rejected_o <= (cmd_i.out_kind == OUT_REJECT);
      if (cmd_i.out_kind == OUT_POS) begin
        pos_x_o <= res_q[0];
        pos_y_o <= res_q[1];
        pos_z_o <= res_q[2];
      end else begin
        pos_x_o <= '0;
        pos_y_o <= '0;
        pos_z_o <= '0;
      end
    end
  end

endmodule

/* sv/kpi_checker.sv */
// ----------------------------------------------------------------------------
// Keyframe path interpolator - port checker
// Watches the top-level ports; bound to every instance of the top level.
// ----------------------------------------------------------------------------
`include "keyframe_path_interpolator_defines.svh"

module kpi_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [127:0] s_axis_tdata_i,
  input logic [1:0]   s_axis_tuser_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [95:0]  m_axis_tdata_o,
  input logic [2:0]   m_axis_tuser_o,
  input logic         psel_i,
  input logic         penable_i,
  input logic         pwrite_i,
  input logic [1:0]   paddr_i,
  input logic [31:0]  pwdata_i,
  input logic [31:0]  prdata_o,
  input logic         pready_o
);

  // a stalled result stays offered
  `KPI_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result dropped while stalled")

  // at most one of pos_valid, motion_done, key_rejected per item
  `KPI_ASSERT(a_flags_excl, clk_i, rst_ni, m_axis_tvalid_o |-> $onehot0(m_axis_tuser_o), "conflicting result flags")

  // no position without pos_valid
  `KPI_ASSERT(a_quiet_pos, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == 96'd0, "position on a quiet item")

  // nothing offered while in reset
  `KPI_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !m_axis_tvalid_o, "result offered in reset")

endmodule

bind keyframe_path_interpolator kpi_checker u_kpi_checker (.*);
